/* src/afc_pkg.sv */
// ----------------------------------------------------------------------------
// afc_pkg
// Shared types, codes and helper functions for the ASCII frame checker.
// ----------------------------------------------------------------------------
package afc_pkg;

    localparam logic [7:0]  ETX_CODE          = 8'h03;
    localparam logic [7:0]  BROADCAST_STATION = 8'h7F;
    localparam logic [15:0] BAD_FIELD         = 16'h8000;
    localparam int          CMD_COUNT         = 13;

    localparam logic [7:0] CMD_TABLE [CMD_COUNT] = '{
        8'h20, 8'h50, 8'h24, 8'h54, 8'h63, 8'h73,
        8'h60, 8'h61, 8'h62, 8'h70, 8'h71, 8'h72, 8'h64
    };

    // command table positions with their own handling
    localparam logic [3:0] IDX_READ_WORD   = 4'd0;   // 0x20
    localparam logic [3:0] IDX_WRITE_WORD  = 4'd1;   // 0x50
    localparam logic [3:0] IDX_READ_BLOCK  = 4'd2;   // 0x24
    localparam logic [3:0] IDX_WRITE_BLOCK = 4'd3;   // 0x54
    localparam logic [3:0] IDX_FIRST_INT   = 4'd4;   // internal commands start here

    // configuration register indexes
    localparam logic CFG_DEVICE_NUMBER   = 1'b0;
    localparam logic CFG_INTERNAL_ENABLE = 1'b1;

    typedef enum logic [1:0] {
        CS_SEARCH,
        CS_PASS,
        CS_FAIL
    } afc_cs_state_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED   = 3'd0,
        ST_CHECKSUM   = 3'd1,
        ST_NOT_CMD    = 3'd2,
        ST_INT_OFF    = 3'd3,
        ST_COUNT_OVER = 3'd4
    } afc_status_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } afc_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  command_index;
        logic [15:0] address_word;
        logic [15:0] block_count;
    } afc_out_t;

    // frame state after the last byte, handed to the verdict logic
    typedef struct packed {
        afc_cs_state_t cs_state;
        logic [7:0]    station;
        logic [7:0]    device;
        logic [7:0]    command;
        logic          last_etx;
        logic [15:0]   addr_acc;
        logic [15:0]   cnt_acc;
    } afc_frame_t;

    // hex digit value, 16 for anything that is not 0-9 or A-F
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = 5'(b - 8'h30);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = 5'(b - 8'h37);
        end else begin
            v = 5'd16;
        end
        return v;
    endfunction

    // shift one hex digit into a 4-digit field; a bad digit sticks as BAD_FIELD
    function automatic logic [15:0] add_digit(input logic [15:0] acc,
                                              input logic        first,
                                              input logic [7:0]  b);
        logic [4:0]  t;
        logic [15:0] r;
        t = hex_value(b);
        if (first) begin
            r = t[4] ? BAD_FIELD : {12'd0, t[3:0]};
        end else if (acc[15]) begin
            r = acc;
        end else if (t[4]) begin
            r = BAD_FIELD;
        end else begin
            r = {acc[11:0], t[3:0]};
        end
        return r;
    endfunction

    // returns {found, index}; codes are distinct so the first hit is the only one
    function automatic logic [4:0] cmd_lookup(input logic [7:0] code);
        logic [4:0] r;
        r = 5'd0;
        for (int k = CMD_COUNT - 1; k >= 0; k--) begin
            if (CMD_TABLE[k] == code) begin
                r = {1'b1, 4'(k)};
            end
        end
        return r;
    endfunction

endpackage

/* src/afc_verdict.sv */
// ----------------------------------------------------------------------------
// afc_verdict
// End-of-frame decision: checksum, command lookup, enables, device match
// and block-count limits, from the frame state including the last byte.
// ----------------------------------------------------------------------------
module afc_verdict #(
    parameter int POS_W           = 9,
    parameter int ADDRESS_OFFSET  = 4,
    parameter int READ_BLOCK_MAX  = 100,
    parameter int WRITE_BLOCK_MAX = 100
) (
    input  afc_pkg::afc_frame_t frame,
    input  logic [POS_W-1:0]    frame_len,
    input  logic [7:0]          device_number,
    input  logic                internal_enable,
    output afc_pkg::afc_out_t   verdict
);
    import afc_pkg::*;

    localparam logic [POS_W-1:0] ADDR_DONE = POS_W'(ADDRESS_OFFSET + 4);
    localparam logic [POS_W-1:0] CNT_DONE  = POS_W'(ADDRESS_OFFSET + 8);
    localparam logic [POS_W-1:0] WB_MIN    = POS_W'(14);
    localparam logic [POS_W-1:0] WB_HDR    = POS_W'(11);
    localparam logic [15:0]      RB_MAX    = 16'(READ_BLOCK_MAX);
    localparam logic [15:0]      WB_MAX    = 16'(WRITE_BLOCK_MAX);

    logic [4:0]       lookup;
    logic             found;
    logic [3:0]       idx;
    logic [15:0]      addr_val;
    logic [15:0]      cnt_val;
    logic             dev_exact;
    logic             dev_bcast;
    logic [POS_W-1:0] wb_body;
    logic [15:0]      wb_count;
    logic             wb_shape_ok;

    assign lookup   = cmd_lookup(frame.command);
    assign found    = lookup[4];
    assign idx      = lookup[3:0];
    assign addr_val = (frame_len >= ADDR_DONE) ? frame.addr_acc : BAD_FIELD;
    assign cnt_val  = (frame_len >= CNT_DONE)  ? frame.cnt_acc  : BAD_FIELD;

    // 9-bit compare so that device 255 plus one never matches
    assign dev_exact = (frame.device == device_number);
    assign dev_bcast = ({1'b0, frame.device} == ({1'b0, device_number} + 9'd1)) &&
                       (frame.station == BROADCAST_STATION);

    assign wb_body     = frame_len - WB_HDR;
    assign wb_count    = 16'(wb_body >> 2);
    assign wb_shape_ok = (frame_len > WB_MIN) && (wb_body[1:0] == 2'b00);

    always_comb begin
        verdict = '0;
        priority if (frame.cs_state != CS_PASS) begin
            verdict.status = ST_CHECKSUM;
        end else if (!found || !frame.last_etx) begin
            verdict.status        = ST_NOT_CMD;
            verdict.command_index = found ? idx : 4'd0;
        end else if (idx >= IDX_FIRST_INT) begin
            verdict.command_index = idx;
            if (internal_enable) begin
                verdict.address_word = addr_val;
            end else begin
                verdict.status = ST_INT_OFF;
            end
        end else begin
            verdict.command_index = idx;
            unique case (idx[1:0])
                IDX_READ_WORD[1:0]: begin
                    if (dev_exact) begin
                        verdict.address_word = addr_val;
                        verdict.block_count  = 16'd1;
                    end else begin
                        verdict.status = ST_NOT_CMD;
                    end
                end
                IDX_WRITE_WORD[1:0]: begin
                    verdict.address_word = addr_val;
                    if (dev_exact || dev_bcast) begin
                        verdict.block_count = 16'd1;
                    end else begin
                        verdict.status = ST_NOT_CMD;
                    end
                end
                IDX_READ_BLOCK[1:0]: begin
                    verdict.address_word = addr_val;
                    verdict.block_count  = cnt_val;
                    if (!dev_exact) begin
                        verdict.status = ST_NOT_CMD;
                    end else if (cnt_val == 16'd0 || cnt_val > RB_MAX) begin
                        verdict.status = ST_COUNT_OVER;
                    end
                end
                IDX_WRITE_BLOCK[1:0]: begin
                    if (wb_shape_ok) begin
                        verdict.address_word = addr_val;
                        verdict.block_count  = wb_count;
                        if (!(dev_exact || dev_bcast)) begin
                            verdict.status = ST_NOT_CMD;
                        end else if (wb_count == 16'd0 || wb_count > WB_MAX) begin
                            verdict.status = ST_COUNT_OVER;
                        end
                    end else begin
                        verdict.status = ST_NOT_CMD;
                    end
                end
                default: verdict.status = ST_NOT_CMD;
            endcase
        end
    end

endmodule

/* src/ascii_frame_checker.sv */
// ----------------------------------------------------------------------------
// ascii_frame_checker
// Checks received ASCII frames with a two-digit hex LRC and gives one
// verdict transaction per frame: checksum, command, enables, device, count.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                                  handshake
//  s_        in   afc_in_t  {rx_byte, frame_end}           s_valid / s_ready
//  m_        out  afc_out_t {status, command_index,        m_valid / m_ready
//                            address_word, block_count}
//  cfg_      in   cfg_index 0 device_number,               cfg_we, no wait
//                           1 internal_enable
//
//  One byte per cycle. Frame state is updated in the cycle a byte is taken;
//  on the frame_end byte the verdict is formed from the updated state and
//  is captured in the output register. The output register is the
//  only stall point: s_ready drops only while a verdict sits unclaimed.
//  Synchronous active-low reset clears the frame state, the output valid
//  and loads the register defaults (device 48, internal commands off).
// ----------------------------------------------------------------------------
module ascii_frame_checker #(
    parameter int BUF_CAPACITY    = 256,
    parameter int ADDRESS_OFFSET  = 4,
    parameter int READ_BLOCK_MAX  = 100,
    parameter int WRITE_BLOCK_MAX = 100
) (
    input  logic              aclk,
    input  logic              aresetn,
    // byte transactions
    input  logic              s_valid,
    output logic              s_ready,
    input  afc_pkg::afc_in_t  s_data,
    // verdict transactions
    output logic              m_valid,
    input  logic              m_ready,
    output afc_pkg::afc_out_t m_data,
    // register writes
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_wdata
);
    import afc_pkg::*;

    // position counter must hold BUF_CAPACITY itself (saturated length)
    localparam int               POS_W    = $clog2(BUF_CAPACITY + 1);
    localparam logic [POS_W-1:0] POS_CAP  = POS_W'(BUF_CAPACITY);
    localparam logic [POS_W-1:0] POS_ST   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_DEV  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_CMD  = POS_W'(3);
    localparam logic [POS_W-1:0] ADDR_LO  = POS_W'(ADDRESS_OFFSET);
    localparam logic [POS_W-1:0] CNT_LO   = POS_W'(ADDRESS_OFFSET + 4);
    localparam logic [POS_W-1:0] CNT_END  = POS_W'(ADDRESS_OFFSET + 8);

    // configuration
    logic [7:0]       device_number_reg;
    logic             internal_enable_reg;

    // frame state
    logic [POS_W-1:0] pos_reg,      pos_next;
    logic [7:0]       sum_reg,      sum_next;
    logic [7:0]       dly0_reg,     dly0_next;   // oldest of the two held bytes
    logic [7:0]       dly1_reg,     dly1_next;
    afc_frame_t       frame_reg,    frame_next;

    // output register
    logic             m_valid_reg;
    afc_out_t         m_data_reg;

    logic             s_fire;
    logic             stored;
    logic [7:0]       b;
    logic [4:0]       cs_hi;
    logic [4:0]       cs_lo;
    logic [7:0]       cs_total;
    afc_out_t         verdict;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign b        = s_data.rx_byte;
    assign stored   = (pos_reg < POS_CAP);   // bytes past capacity are dropped
    assign cs_hi    = hex_value(dly0_reg);
    assign cs_lo    = hex_value(dly1_reg);
    assign cs_total = sum_reg + {cs_hi[3:0], 4'h0} + {4'h0, cs_lo[3:0]};

    // ---- per-byte frame state update ----
    always_comb begin
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        dly0_next  = dly0_reg;
        dly1_next  = dly1_reg;
        frame_next = frame_reg;
        if (stored) begin
            if (pos_reg == POS_ST)  frame_next.station = b;
            if (pos_reg == POS_DEV) frame_next.device  = b;
            if (pos_reg == POS_CMD) frame_next.command = b;

            // checksum digits trail two bytes behind; first ETX closes the sum
            if (frame_reg.cs_state == CS_SEARCH && pos_reg >= POS_CMD) begin
                if (b == ETX_CODE) begin
                    frame_next.cs_state = (!cs_hi[4] && !cs_lo[4] && cs_total == 8'h00)
                                          ? CS_PASS : CS_FAIL;
                end else begin
                    sum_next = sum_reg + dly0_reg;
                end
            end
            dly0_next = dly1_reg;
            dly1_next = b;

            if (pos_reg >= ADDR_LO && pos_reg < CNT_LO) begin
                frame_next.addr_acc = add_digit(frame_reg.addr_acc, pos_reg == ADDR_LO, b);
            end
            if (pos_reg >= CNT_LO && pos_reg < CNT_END) begin
                frame_next.cnt_acc = add_digit(frame_reg.cnt_acc, pos_reg == CNT_LO, b);
            end
            frame_next.last_etx = (b == ETX_CODE);
            pos_next = pos_reg + POS_W'(1);
        end
    end

    afc_verdict #(
        .POS_W           (POS_W),
        .ADDRESS_OFFSET  (ADDRESS_OFFSET),
        .READ_BLOCK_MAX  (READ_BLOCK_MAX),
        .WRITE_BLOCK_MAX (WRITE_BLOCK_MAX)
    ) u_verdict (
        .frame           (frame_next),
        .frame_len       (pos_next),
        .device_number   (device_number_reg),
        .internal_enable (internal_enable_reg),
        .verdict         (verdict)
    );

    // ---- configuration registers ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_number_reg   <= 8'd48;
            internal_enable_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_DEVICE_NUMBER:   device_number_reg   <= cfg_wdata;
                CFG_INTERNAL_ENABLE: internal_enable_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ---- frame state; cleared after every frame end ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            sum_reg   <= '0;
            dly0_reg  <= '0;
            dly1_reg  <= '0;
            frame_reg <= '{cs_state: CS_SEARCH, default: '0};
        end else if (s_fire) begin
            if (s_data.frame_end) begin
                pos_reg   <= '0;
                sum_reg   <= '0;
                dly0_reg  <= '0;
                dly1_reg  <= '0;
                frame_reg <= '{cs_state: CS_SEARCH, default: '0};
            end else begin
                pos_reg   <= pos_next;
                sum_reg   <= sum_next;
                dly0_reg  <= dly0_next;
                dly1_reg  <= dly1_next;
                frame_reg <= frame_next;
            end
        end
    end

    // ---- verdict output register ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire && s_data.frame_end) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && s_data.frame_end) begin
            m_data_reg <= verdict;
        end
    end

endmodule
